[rtl/sukt_pkg.sv]
// shared types and codes for the sorted unique-key table
// no dependencies
package sukt_pkg;

  localparam int unsigned KeyW      = 34;
  localparam int unsigned PayloadW  = 32;
  localparam int unsigned CountOutW = 7;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
  } entry_t;

endpackage

[rtl/sorted_unique_key_table.sv]
// top level of the sorted unique-key table: one entry memory and its walking sequencer
// depends on sukt_pkg
//
// A request word is taken when start is high and busy is low. Entries are
// kept in one single-port-read memory, sorted by key with the largest at
// entry 0. Insert, remove and search walk the memory from entry 0, one entry
// a cycle, and insert and remove shift the later entries up or down as they
// go. Clear empties the table without a walk. busy is high for the whole walk
// and falls in the cycle the result is shown, so the next word may be accepted
// then. Each result word stands on status_o, found_payload_o and entry_count_o
// for exactly one cycle, marked by done_o; the receiver cannot hold it off and
// must take it in that cycle. The memory needs no clearing pass after reset:
// only entries below the count ever take part in a result.
module sorted_unique_key_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     kind_i,
  input  logic [sukt_pkg::KeyW-1:0]      key_i,
  input  logic [sukt_pkg::PayloadW-1:0]  payload_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [sukt_pkg::PayloadW-1:0]  found_payload_o,
  output logic [sukt_pkg::CountOutW-1:0] entry_count_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN
  } state_e;

  state_e                           state_q;
  sukt_pkg::kind_e                  kind_q;
  logic [sukt_pkg::KeyW-1:0]        key_q;
  logic [sukt_pkg::PayloadW-1:0]    pay_q;
  logic [CW-1:0]                    count_q;
  logic [CW-1:0]                    idx_q;     // entry whose data sits in rdata_q
  sukt_pkg::entry_t                 carry_q;   // entry displaced by an insert
  logic                             done_q;
  sukt_pkg::status_e                status_q;
  logic [sukt_pkg::PayloadW-1:0]    found_q;

  // entry memory
  sukt_pkg::entry_t mem_q [CAPACITY];
  sukt_pkg::entry_t rdata_q;

  logic [CW-1:0]    idx_nxt;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  sukt_pkg::entry_t wr_data;
  sukt_pkg::entry_t new_entry;

  logic at_end;   // walked past the last held entry
  logic full;
  logic hit;      // entry under the walk holds the request key
  logic below;    // entry under the walk has a smaller key: insert point
  logic last;     // entry under the walk is the last held one

  assign idx_nxt   = idx_q + CW'(1);
  assign at_end    = (idx_q == count_q);
  assign full      = (count_q == CW'(CAPACITY));
  assign hit       = (rdata_q.key == key_q);
  assign below     = (rdata_q.key < key_q);
  assign last      = (idx_nxt == count_q);
  assign new_entry = '{key: key_q, payload: pay_q};

  // read the next entry each cycle; entry 0 while waiting for a request
  assign rd_addr = (state_q == S_IDLE) ? '0 : idx_nxt[IW-1:0];

  // write port: place the new entry, push the carried one up, or pull one down
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q[IW-1:0];
    wr_data = new_entry;
    unique case (state_q)
      S_SCAN: begin
        if (kind_q == sukt_pkg::KIND_INSERT && !full) begin
          wr_en = at_end || (!hit && below);
        end
      end
      S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_data = carry_q;
      end
      S_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = IW'(idx_q - CW'(1));
        wr_data = rdata_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      done_q   <= 1'b0;
      status_q <= sukt_pkg::ST_OK;
      found_q  <= '0;
      kind_q   <= sukt_pkg::KIND_INSERT;
      key_q    <= '0;
      pay_q    <= '0;
      carry_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            kind_q   <= sukt_pkg::kind_e'(kind_i);
            key_q    <= key_i;
            pay_q    <= payload_i;
            idx_q    <= '0;
            status_q <= sukt_pkg::ST_OK;
            found_q  <= '0;
            if (sukt_pkg::kind_e'(kind_i) == sukt_pkg::KIND_CLEAR) begin
              count_q <= '0;
              done_q  <= 1'b1;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          idx_q <= idx_nxt;
          if (at_end) begin
            // key not among the held entries
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            if (kind_q == sukt_pkg::KIND_INSERT) begin
              if (full) begin
                status_q <= sukt_pkg::ST_FULL;
              end else begin
                count_q <= count_q + CW'(1);
              end
            end else begin
              status_q <= sukt_pkg::ST_MISSING;
            end
          end else begin
            unique case (kind_q)
              sukt_pkg::KIND_INSERT: begin
                if (hit) begin
                  status_q <= sukt_pkg::ST_DUP;
                  state_q  <= S_IDLE;
                  done_q   <= 1'b1;
                end else if (below) begin
                  if (full) begin
                    status_q <= sukt_pkg::ST_FULL;
                    state_q  <= S_IDLE;
                    done_q   <= 1'b1;
                  end else begin
                    carry_q <= rdata_q;
                    state_q <= S_SHIFT_UP;
                  end
                end
              end
              sukt_pkg::KIND_REMOVE: begin
                if (hit) begin
                  if (last) begin
                    count_q <= count_q - CW'(1);
                    state_q <= S_IDLE;
                    done_q  <= 1'b1;
                  end else begin
                    state_q <= S_SHIFT_DN;
                  end
                end
              end
              sukt_pkg::KIND_SEARCH: begin
                if (hit) begin
                  found_q <= rdata_q.payload;
                  state_q <= S_IDLE;
                  done_q  <= 1'b1;
                end
              end
              default: begin
                state_q <= S_IDLE;
                done_q  <= 1'b1;
              end
            endcase
          end
        end

        S_SHIFT_UP: begin
          // carried entry goes to this slot, the old one moves on
          idx_q   <= idx_nxt;
          carry_q <= rdata_q;
          if (at_end) begin
            count_q <= count_q + CW'(1);
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end

        S_SHIFT_DN: begin
          idx_q <= idx_nxt;
          if (last) begin
            count_q <= count_q - CW'(1);
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign found_payload_o = found_q;
  assign entry_count_o   = sukt_pkg::CountOutW'(count_q);

endmodule
